// ----- hw/rtl/sbda_pkg.sv -----
// ============================================================================
// sbda_pkg: shared types and constants for the scene bounds core
// Coordinate widths, payload structs, controller states and the command and
// status groups that pass between the controller and the datapath.
// ============================================================================
package sbda_pkg;

    // Vertex coordinates are signed Q12.12.
    localparam int COORD_BITS = 24;
    // Edge vectors between two vertices need one extra bit.
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;
    localparam int AREA_BITS  = 64;
    localparam int SAT_BITS   = (CROSS_BITS > AREA_BITS) ? CROSS_BITS : AREA_BITS;
    localparam int SCALE_BITS = 32;
    localparam int AXIS_BITS  = 2;
    localparam int FILL_BITS  = 2;

    // 1.8 in Q16.16 scaled by the Q12.12 extent: 1.8 * 2^28.
    localparam int SCALE_NUMERATOR_INT = 483183821;
    localparam int NUM_BITS  = $clog2(SCALE_NUMERATOR_INT + 1);
    localparam int DCNT_BITS = $clog2(NUM_BITS);

    localparam logic [NUM_BITS-1:0]   SCALE_NUMERATOR = NUM_BITS'(SCALE_NUMERATOR_INT);
    localparam logic [SCALE_BITS-1:0] UNIT_SCALE      = SCALE_BITS'(65536);
    localparam logic [AREA_BITS-1:0]  AREA_MAX        = {AREA_BITS{1'b1}};
    localparam logic [FILL_BITS-1:0]  FILL_EMPTY      = FILL_BITS'(0);
    localparam logic [FILL_BITS-1:0]  FILL_FULL       = FILL_BITS'(2);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic [COORD_BITS-1:0]        extent_t;
    typedef logic [AREA_BITS-1:0]         area_t;
    typedef logic [AXIS_BITS-1:0]         axis_t;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        coord_t pos_z;
        logic   strip_mesh;
        logic   draw_start;
        logic   last_item;
    } vertex_t;

    typedef struct packed {
        axis_t                 depth_sel;
        axis_t                 horiz_sel;
        axis_t                 vert_sel;
        coord_t                min_x;
        coord_t                min_y;
        coord_t                min_z;
        coord_t                max_x;
        coord_t                max_y;
        coord_t                max_z;
        coord_t                mid_horiz;
        coord_t                mid_vert;
        logic [SCALE_BITS-1:0] view_scale;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CROSS,
        ST_ACC,
        ST_EXTENT,
        ST_DECIDE,
        ST_SETUP,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic cross_step;
        logic acc;
        logic extent;
        logic decide;
        logic setup;
        logic div_step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic tri_in;
        logic last_in;
        logic last_held;
        logic div_last;
    } ctrl_status_t;

endpackage

// ----- hw/rtl/sbda_ctrl.sv -----
// ============================================================================
// sbda_ctrl: sequencing state machine
// Steps each vertex that closes a strip triangle through the area pipeline and,
// on the last vertex, through the axis decision, the scale division and the result.
// ============================================================================
module sbda_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  sbda_pkg::ctrl_status_t status,
    output sbda_pkg::ctrl_cmd_t    cmd,
    output logic                  busy
);

    sbda_pkg::state_t state_reg;
    sbda_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbda_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (status.tri_in)
                    begin
                        state_next = sbda_pkg::ST_MUL;
                    end
                    else if (status.last_in)
                    begin
                        state_next = sbda_pkg::ST_EXTENT;
                    end
                end
            end
            sbda_pkg::ST_MUL:    state_next = sbda_pkg::ST_CROSS;
            sbda_pkg::ST_CROSS:  state_next = sbda_pkg::ST_ACC;
            sbda_pkg::ST_ACC:
            begin
                state_next = status.last_held ? sbda_pkg::ST_EXTENT : sbda_pkg::ST_IDLE;
            end
            sbda_pkg::ST_EXTENT: state_next = sbda_pkg::ST_DECIDE;
            sbda_pkg::ST_DECIDE: state_next = sbda_pkg::ST_SETUP;
            sbda_pkg::ST_SETUP:  state_next = sbda_pkg::ST_DIV;
            sbda_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = sbda_pkg::ST_DONE;
                end
            end
            sbda_pkg::ST_DONE:   state_next = sbda_pkg::ST_IDLE;
            default:             state_next = sbda_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            sbda_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            sbda_pkg::ST_MUL:    cmd.mul        = 1'b1;
            sbda_pkg::ST_CROSS:  cmd.cross_step = 1'b1;
            sbda_pkg::ST_ACC:    cmd.acc        = 1'b1;
            sbda_pkg::ST_EXTENT: cmd.extent     = 1'b1;
            sbda_pkg::ST_DECIDE: cmd.decide     = 1'b1;
            sbda_pkg::ST_SETUP:  cmd.setup      = 1'b1;
            sbda_pkg::ST_DIV:    cmd.div_step   = 1'b1;
            sbda_pkg::ST_DONE:   cmd.finish     = 1'b1;
            default:             busy           = 1'b1;
        endcase
    end

endmodule

// ----- hw/rtl/sbda_divider.sv -----
// ============================================================================
// sbda_divider: restoring divider for the view scale
// Divides the fixed scale numerator by the visible extent, one quotient bit
// per step, most significant bit first.
// ============================================================================
module sbda_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic                                step,
    input  logic [sbda_pkg::COORD_BITS-1:0]     divisor,
    output logic [sbda_pkg::NUM_BITS-1:0]       quotient,
    output logic                                last
);

    localparam int C = sbda_pkg::COORD_BITS;
    localparam int N = sbda_pkg::NUM_BITS;

    logic [C-1:0]                    den_reg;
    logic [C-1:0]                    rem_reg;
    logic [C-1:0]                    rem_next;
    logic [N-1:0]                    quo_reg;
    logic [N-1:0]                    quo_next;
    logic [sbda_pkg::DCNT_BITS-1:0]  cnt_reg;
    logic [C:0]                      trial;
    logic                            fits;

    // The quotient register doubles as the numerator shift register.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[N-1]};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? C'(trial - {1'b0, den_reg}) : trial[C-1:0];
        quo_next = {quo_reg[N-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= sbda_pkg::DCNT_BITS'(N - 1);
        end
        else if (step && (cnt_reg != '0))
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= sbda_pkg::SCALE_NUMERATOR;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign last     = (cnt_reg == '0);

endmodule

// ----- hw/rtl/sbda_datapath.sv -----
// ============================================================================
// sbda_datapath: bounding box, strip area sums and result assembly
// Holds the running box, the two prior strip vertices and the saturating
// projected-area sums, and forms the result under controller commands.
// ============================================================================
module sbda_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sbda_pkg::vertex_t        vertex,
    input  sbda_pkg::ctrl_cmd_t      cmd,
    output sbda_pkg::ctrl_status_t   status,
    output sbda_pkg::result_t        result,
    output logic                    done
);

    localparam int C  = sbda_pkg::COORD_BITS;
    localparam int D  = sbda_pkg::DIFF_BITS;
    localparam int P  = sbda_pkg::PROD_BITS;
    localparam int X  = sbda_pkg::CROSS_BITS;
    localparam int A  = sbda_pkg::AREA_BITS;
    localparam int S  = sbda_pkg::SAT_BITS;

    sbda_pkg::coord_t   v_in [3];
    sbda_pkg::coord_t   box_low_reg [3];
    sbda_pkg::coord_t   box_high_reg [3];
    sbda_pkg::coord_t   prior_a_reg [3];
    sbda_pkg::coord_t   prior_b_reg [3];
    sbda_pkg::diff_t    ab_reg [3];
    sbda_pkg::diff_t    ac_reg [3];
    sbda_pkg::prod_t    prod_reg [6];
    sbda_pkg::area_t    cross_reg [3];
    sbda_pkg::area_t    cross_next [3];
    sbda_pkg::area_t    area_reg [3];
    sbda_pkg::area_t    area_next [3];
    sbda_pkg::extent_t  ext_reg [3];
    logic [sbda_pkg::FILL_BITS-1:0] fill_reg;
    logic [sbda_pkg::FILL_BITS-1:0] fill_eff;
    logic               tri_in;
    logic               last_reg;
    logic               done_reg;

    sbda_pkg::axis_t    depth_reg;
    sbda_pkg::axis_t    depth_next;
    sbda_pkg::axis_t    horiz_reg;
    sbda_pkg::axis_t    vert_reg;
    sbda_pkg::axis_t    horiz_next;
    sbda_pkg::axis_t    vert_next;
    sbda_pkg::coord_t   cen_h_reg;
    sbda_pkg::coord_t   cen_v_reg;
    sbda_pkg::coord_t   cen_h_next;
    sbda_pkg::coord_t   cen_v_next;
    sbda_pkg::extent_t  ext_h;
    sbda_pkg::extent_t  ext_v;
    sbda_pkg::extent_t  vis;
    logic               vis_zero_reg;
    sbda_pkg::result_t  result_reg;
    logic [sbda_pkg::NUM_BITS-1:0] quotient;
    logic               div_last;

    function automatic sbda_pkg::coord_t pick_coord(input sbda_pkg::axis_t ax,
                                                    input sbda_pkg::coord_t c0,
                                                    input sbda_pkg::coord_t c1,
                                                    input sbda_pkg::coord_t c2);
        sbda_pkg::coord_t r;
        unique case (ax)
            sbda_pkg::AXIS_X: r = c0;
            sbda_pkg::AXIS_Y: r = c1;
            default:          r = c2;
        endcase
        return r;
    endfunction

    function automatic sbda_pkg::coord_t centre(input sbda_pkg::coord_t lo,
                                                input sbda_pkg::coord_t hi);
        sbda_pkg::diff_t s;
        s = sbda_pkg::diff_t'(lo) + sbda_pkg::diff_t'(hi);
        return C'(s >>> 1);
    endfunction

    assign v_in[0] = vertex.pos_x;
    assign v_in[1] = vertex.pos_y;
    assign v_in[2] = vertex.pos_z;

    // A draw start or a vertex outside a strip empties the strip first.
    assign fill_eff = (vertex.draw_start || !vertex.strip_mesh) ? sbda_pkg::FILL_EMPTY
                                                               : fill_reg;
    assign tri_in   = vertex.strip_mesh && (fill_eff == sbda_pkg::FILL_FULL);

    // Cross-product magnitudes, clipped to the sum width.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [X-1:0] d;
            logic [X-1:0]        m;
            logic [S-1:0]        w;
            d = X'(prod_reg[2*i]) - X'(prod_reg[2*i+1]);
            m = d[X-1] ? X'(-d) : X'(d);
            w = S'(m);
            cross_next[i] = (w > S'(sbda_pkg::AREA_MAX)) ? sbda_pkg::AREA_MAX : A'(w);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [A:0] s;
            s = {1'b0, area_reg[i]} + {1'b0, cross_reg[i]};
            area_next[i] = s[A] ? sbda_pkg::AREA_MAX : s[A-1:0];
        end
    end

    // Largest area wins; with no area at all the smallest extent wins.
    always_comb
    begin
        depth_next = sbda_pkg::AXIS_X;
        if ((area_reg[0] != '0) || (area_reg[1] != '0) || (area_reg[2] != '0))
        begin
            if (area_reg[1] > area_reg[0])
            begin
                depth_next = sbda_pkg::AXIS_Y;
            end
            if (area_reg[2] > ((depth_next == sbda_pkg::AXIS_Y) ? area_reg[1] : area_reg[0]))
            begin
                depth_next = sbda_pkg::AXIS_Z;
            end
        end
        else
        begin
            if (ext_reg[1] < ext_reg[0])
            begin
                depth_next = sbda_pkg::AXIS_Y;
            end
            if (ext_reg[2] < ((depth_next == sbda_pkg::AXIS_Y) ? ext_reg[1] : ext_reg[0]))
            begin
                depth_next = sbda_pkg::AXIS_Z;
            end
        end
    end

    always_comb
    begin
        horiz_next = (depth_reg == sbda_pkg::AXIS_X) ? sbda_pkg::AXIS_Y : sbda_pkg::AXIS_X;
        vert_next  = (depth_reg == sbda_pkg::AXIS_Z) ? sbda_pkg::AXIS_Y : sbda_pkg::AXIS_Z;
        ext_h      = pick_coord(horiz_next, ext_reg[0], ext_reg[1], ext_reg[2]);
        ext_v      = pick_coord(vert_next, ext_reg[0], ext_reg[1], ext_reg[2]);
        vis        = (ext_h > ext_v) ? ext_h : ext_v;
        cen_h_next = centre(pick_coord(horiz_next, box_low_reg[0], box_low_reg[1],
                                       box_low_reg[2]),
                            pick_coord(horiz_next, box_high_reg[0], box_high_reg[1],
                                       box_high_reg[2]));
        cen_v_next = centre(pick_coord(vert_next, box_low_reg[0], box_low_reg[1],
                                       box_low_reg[2]),
                            pick_coord(vert_next, box_high_reg[0], box_high_reg[1],
                                       box_high_reg[2]));
    end

    sbda_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.setup),
        .step     (cmd.div_step),
        .divisor  (vis),
        .quotient (quotient),
        .last     (div_last)
    );

    // Scene state: cleared by reset and again after each result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                box_low_reg[i]  <= sbda_pkg::COORD_MAX;
                box_high_reg[i] <= sbda_pkg::COORD_MIN;
                prior_a_reg[i]  <= '0;
                prior_b_reg[i]  <= '0;
                area_reg[i]     <= '0;
            end
            fill_reg <= sbda_pkg::FILL_EMPTY;
            last_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.load)
            begin
                last_reg <= vertex.last_item;
                for (int i = 0; i < 3; i++)
                begin
                    if (v_in[i] < box_low_reg[i])
                    begin
                        box_low_reg[i] <= v_in[i];
                    end
                    if (v_in[i] > box_high_reg[i])
                    begin
                        box_high_reg[i] <= v_in[i];
                    end
                end
                if (vertex.strip_mesh)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        prior_a_reg[i] <= prior_b_reg[i];
                        prior_b_reg[i] <= v_in[i];
                    end
                    fill_reg <= (fill_eff == sbda_pkg::FILL_FULL) ? sbda_pkg::FILL_FULL
                                                                 : fill_eff + 1'b1;
                end
                else
                begin
                    fill_reg <= sbda_pkg::FILL_EMPTY;
                end
            end
            else if (cmd.acc)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    area_reg[i] <= area_next[i];
                end
            end
            else if (cmd.finish)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    box_low_reg[i]  <= sbda_pkg::COORD_MAX;
                    box_high_reg[i] <= sbda_pkg::COORD_MIN;
                    prior_a_reg[i]  <= '0;
                    prior_b_reg[i]  <= '0;
                    area_reg[i]     <= '0;
                end
                fill_reg <= sbda_pkg::FILL_EMPTY;
                last_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ab_reg[i] <= D'(prior_b_reg[i]) - D'(prior_a_reg[i]);
                ac_reg[i] <= D'(v_in[i]) - D'(prior_a_reg[i]);
            end
        end
        if (cmd.mul)
        begin
            prod_reg[0] <= P'(ab_reg[1]) * P'(ac_reg[2]);
            prod_reg[1] <= P'(ab_reg[2]) * P'(ac_reg[1]);
            prod_reg[2] <= P'(ab_reg[2]) * P'(ac_reg[0]);
            prod_reg[3] <= P'(ab_reg[0]) * P'(ac_reg[2]);
            prod_reg[4] <= P'(ab_reg[0]) * P'(ac_reg[1]);
            prod_reg[5] <= P'(ab_reg[1]) * P'(ac_reg[0]);
        end
        if (cmd.cross_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cross_reg[i] <= cross_next[i];
            end
        end
        if (cmd.extent)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ext_reg[i] <= C'(D'(box_high_reg[i]) - D'(box_low_reg[i]));
            end
        end
        if (cmd.decide)
        begin
            depth_reg <= depth_next;
        end
        if (cmd.setup)
        begin
            horiz_reg    <= horiz_next;
            vert_reg     <= vert_next;
            cen_h_reg    <= cen_h_next;
            cen_v_reg    <= cen_v_next;
            vis_zero_reg <= (vis == '0);
        end
        if (cmd.finish)
        begin
            result_reg.depth_sel  <= depth_reg;
            result_reg.horiz_sel  <= horiz_reg;
            result_reg.vert_sel   <= vert_reg;
            result_reg.min_x      <= box_low_reg[0];
            result_reg.min_y      <= box_low_reg[1];
            result_reg.min_z      <= box_low_reg[2];
            result_reg.max_x      <= box_high_reg[0];
            result_reg.max_y      <= box_high_reg[1];
            result_reg.max_z      <= box_high_reg[2];
            result_reg.mid_horiz  <= cen_h_reg;
            result_reg.mid_vert   <= cen_v_reg;
            result_reg.view_scale <= vis_zero_reg ? sbda_pkg::UNIT_SCALE
                                                  : sbda_pkg::SCALE_BITS'(quotient);
        end
    end

    assign status.tri_in    = tri_in;
    assign status.last_in   = vertex.last_item;
    assign status.last_held = last_reg;
    assign status.div_last  = div_last;
    assign result           = result_reg;
    assign done             = done_reg;

endmodule

// ----- hw/rtl/scene_bounds_dominant_axis_core.sv -----
// ============================================================================
// scene_bounds_dominant_axis_core: scene bounds and dominant viewing axis
// Accumulates an axis-aligned bounding box and strip projected-area sums over
// a vertex stream and, on the last vertex, reports the box, the depth axis,
// the two view axes with their centres and the Q16.16 view scale.
// ============================================================================
//
//  Channel   Ports                   Direction  Transaction taken when
//  --------  ----------------------  ---------  ------------------------------
//  vertex    start, busy, vertex     in         rising edge, start && !busy
//  result    done, result            out        rising edge while done is high
//
// A vertex that forms no triangle and is not the last leaves busy low, so
// such vertices may be offered in every cycle. A vertex that closes a strip
// triangle holds busy through the multiply, cross term and accumulate states.
// The last vertex adds the extent, decision and setup states, the steps of
// the bit-serial scale divider and a finish state, after the triangle states
// when it also closes a triangle. done is high in the first cycle in which
// busy is low again. Reset is asynchronous and active low and returns
// the box, area sums and strip history to their empty values, as does every
// result. The receiver cannot stall: done lasts exactly one cycle.
//
module scene_bounds_dominant_axis_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sbda_pkg::vertex_t  vertex,
    output logic               busy,
    output logic               done,
    output sbda_pkg::result_t  result
);

    // Command and status groups between the sequencer and the datapath.
    sbda_pkg::ctrl_cmd_t     cmd;
    sbda_pkg::ctrl_status_t  status;

    // The sequencer decides, from the incoming vertex, whether a triangle
    // or the end of the scene needs further cycles.
    sbda_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // The datapath holds all scene state and the registered result.
    sbda_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .vertex (vertex),
        .cmd    (cmd),
        .status (status),
        .result (result),
        .done   (done)
    );

    // A result is always preceded by a busy finish cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // A vertex that is not the last of a scene never produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !vertex.last_item) |=> !done)
        else $error("result produced by a vertex that is not the last");

    // Results are never back to back.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for more than one cycle");

    // The depth axis differs from both view axes, and the view axes differ.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.depth_sel != result.horiz_sel) &&
                  (result.depth_sel != result.vert_sel) &&
                  (result.horiz_sel != result.vert_sel)))
        else $error("view axes collide with the depth axis");

endmodule
